@@ rtl/core/pss_pkg.sv @@
// shared types, sizes and codes for the priority-sweep process scheduler
// no dependencies; used by the interfaces, the engine, the top level and the checker
`timescale 1ns / 1ps

package pss_pkg;

    localparam int SLOTS        = 32;
    localparam int MAX_PRIORITY = 127;

    localparam int PRIO_W   = 7;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = $clog2(SLOTS);
    localparam int CNT_W    = $clog2(SLOTS + 1);
    localparam int THR_W    = $clog2(MAX_PRIORITY + 1);
    localparam int CMP_W    = (THR_W > PRIO_W) ? THR_W : PRIO_W;
    localparam int SPAN     = SLOTS * (MAX_PRIORITY + 1);
    localparam int SPAN_W   = $clog2(SPAN + 1);

    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_PICK = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_ADDED  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_PICKED = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE   = 2'd3;

    typedef struct packed {
        logic              func;
        logic [PRIO_W-1:0] priority_req;
        logic              mode;
    } pss_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [PRIO_W-1:0]   slot_priority;
        logic                slot_mode;
    } pss_res_t;

    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic              mode;
    } pss_entry_t;

endpackage

@@ rtl/core/pss_req_if.sv @@
// request channel: valid/ready handshake carrying one scheduler command
// depends on pss_pkg for field widths
`timescale 1ns / 1ps

interface pss_req_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [pss_pkg::PRIO_W-1:0] priority_req;
    logic                       mode;

    modport source (output valid, output func, output priority_req, output mode,
                    input ready);
    modport sink   (input valid, input func, input priority_req, input mode,
                    output ready);
endinterface

@@ rtl/core/pss_res_if.sv @@
// result channel: valid/ready handshake carrying one scheduler answer
// depends on pss_pkg for field widths
`timescale 1ns / 1ps

interface pss_res_if;
    logic                         valid;
    logic                         ready;
    logic [pss_pkg::STATUS_W-1:0] status;
    logic [pss_pkg::SLOT_W-1:0]   slot;
    logic [pss_pkg::PRIO_W-1:0]   slot_priority;
    logic                         slot_mode;

    modport source (output valid, output status, output slot, output slot_priority,
                    output slot_mode, input ready);
    modport sink   (input valid, input status, input slot, input slot_priority,
                    input slot_mode, output ready);
endinterface

@@ rtl/core/pss_engine.sv @@
// slot table and sweep sequencer: handles one add or pick at a time
// depends on pss_pkg; instantiated by priority_sweep_process_scheduler
`timescale 1ns / 1ps

module pss_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  pss_pkg::pss_req_t req,
    input  logic              res_ready,
    output logic              idle,
    output logic              done,
    output pss_pkg::pss_res_t res
);
    import pss_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SLOT_W-1:0] scan_ptr_reg, scan_ptr_next;
    logic [THR_W-1:0]  sweep_thr_reg, sweep_thr_next;
    logic [SPAN_W-1:0] issued_reg, issued_next;
    logic              chk_valid_reg, chk_valid_next;

    logic [SLOT_W-1:0] work_ptr_reg, work_ptr_next;
    logic [THR_W-1:0]  work_thr_reg, work_thr_next;
    logic [SLOT_W-1:0] chk_ptr_reg, chk_ptr_next;
    logic [THR_W-1:0]  chk_thr_reg, chk_thr_next;
    pss_res_t          res_reg, res_next;

    pss_entry_t        mem [SLOTS];
    pss_entry_t        rd_data_reg;
    logic              mem_we;
    logic [SLOT_W-1:0] mem_waddr;
    pss_entry_t        mem_wdata;

    logic              issue;
    logic              hit;
    logic [THR_W-1:0]  thr_dec;
    logic [SLOT_W-1:0] work_ptr_inc;
    logic [SLOT_W-1:0] chk_ptr_inc;

    // table memory, read port follows the working pointer every cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[work_ptr_reg];
    end

    assign thr_dec      = (work_thr_reg == '0) ? THR_W'(MAX_PRIORITY)
                                               : work_thr_reg - THR_W'(1);
    assign work_ptr_inc = (work_ptr_reg == SLOT_W'(SLOTS - 1)) ? '0
                                                               : work_ptr_reg + SLOT_W'(1);
    assign chk_ptr_inc  = (chk_ptr_reg == SLOT_W'(SLOTS - 1)) ? '0
                                                              : chk_ptr_reg + SLOT_W'(1);
    assign issue        = (issued_reg != SPAN_W'(SPAN));

    // slots are never freed, so the used slots are exactly those below the fill count
    assign hit = chk_valid_reg && (CNT_W'(chk_ptr_reg) < count_reg)
                 && (CMP_W'(rd_data_reg.prio) >= CMP_W'(chk_thr_reg));

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_ptr_next  = scan_ptr_reg;
        sweep_thr_next = sweep_thr_reg;
        issued_next    = issued_reg;
        chk_valid_next = chk_valid_reg;
        work_ptr_next  = work_ptr_reg;
        work_thr_next  = work_thr_reg;
        chk_ptr_next   = chk_ptr_reg;
        chk_thr_next   = chk_thr_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = count_reg[SLOT_W-1:0];
        mem_wdata      = '{prio: req.priority_req, mode: req.mode};

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DONE;
                    if (req.func == FUNC_ADD)
                    begin
                        if (count_reg < CNT_W'(SLOTS))
                        begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            res_next   = '{status: STATUS_ADDED,
                                           slot: count_reg[SLOT_W-1:0],
                                           slot_priority: req.priority_req,
                                           slot_mode: req.mode};
                        end
                        else
                        begin
                            res_next = '{status: STATUS_FULL, default: '0};
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next = '{status: STATUS_NONE, default: '0};
                    end
                    else
                    begin
                        state_next     = S_SCAN;
                        work_ptr_next  = scan_ptr_reg;
                        work_thr_next  = sweep_thr_reg;
                        issued_next    = '0;
                        chk_valid_next = 1'b0;
                    end
                end
            end
            S_SCAN:
            begin
                // probe issue: threshold steps down, memory read starts at the pointer
                chk_valid_next = issue;
                if (issue)
                begin
                    chk_ptr_next  = work_ptr_reg;
                    chk_thr_next  = thr_dec;
                    work_ptr_next = work_ptr_inc;
                    work_thr_next = thr_dec;
                    issued_next   = issued_reg + SPAN_W'(1);
                end
                // probe check in the cycle after its issue; a probe in flight on a hit is dropped
                if (hit)
                begin
                    state_next     = S_DONE;
                    scan_ptr_next  = chk_ptr_inc;
                    sweep_thr_next = chk_thr_reg;
                    res_next       = '{status: STATUS_PICKED,
                                       slot: chk_ptr_reg,
                                       slot_priority: rd_data_reg.prio,
                                       slot_mode: rd_data_reg.mode};
                end
                else if (!issue && !chk_valid_reg)
                begin
                    // all SLOTS * (MAX_PRIORITY + 1) probes issued and checked without a match
                    state_next = S_DONE;
                    res_next   = '{status: STATUS_NONE, default: '0};
                end
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_ptr_reg  <= '0;
            sweep_thr_reg <= '0;
            issued_reg    <= '0;
            chk_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_ptr_reg  <= scan_ptr_next;
            sweep_thr_reg <= sweep_thr_next;
            issued_reg    <= issued_next;
            chk_valid_reg <= chk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_ptr_reg <= work_ptr_next;
        work_thr_reg <= work_thr_next;
        chk_ptr_reg  <= chk_ptr_next;
        chk_thr_reg  <= chk_thr_next;
        res_reg      <= res_next;
    end

    assign idle = (state_reg == S_IDLE);
    assign done = (state_reg == S_DONE) && res_ready;
    assign res  = res_reg;

endmodule

@@ rtl/core/priority_sweep_process_scheduler.sv @@
// Priority-sweep process scheduler.
// Channels: req (sink) carries func, priority_req and mode; rsp (source) carries
// status, slot, slot_priority and slot_mode. A transaction moves on a rising edge
// with valid and ready both high; every request gives exactly one response.
// An add places the process in the lowest free slot (status added) or reports
// table full. A pick probes slots round robin from the scan pointer while a
// threshold counts down and wraps to the maximum priority; the first used slot
// whose priority reaches the threshold is picked, else status nothing runnable.
// Timing: an add, or a pick on an empty table, is answered without probing. A pick
// answers from the check of its first matching probe; a sweep through all
// 32 * 128 = 4096 probes without a match answers nothing runnable. Responses
// pass from the engine's result register to the output register. One probe per
// cycle, set by the single read port of the slot table.
// Throughput: one request at a time; req.ready is high only while the engine
// is idle, so a new request is taken right after the previous one hands its
// response to the output register.
// Reset: all slots free, scan pointer and threshold zero; no clearing pass.
// A stalled receiver holds the response in the output register; the engine
// finishes the next request and waits with it until the register frees.
// depends on pss_pkg, pss_req_if, pss_res_if and pss_engine
`timescale 1ns / 1ps

module priority_sweep_process_scheduler
(
    input logic   clk,
    input logic   rst_n,
    pss_req_if.sink   req,
    pss_res_if.source rsp
);
    import pss_pkg::*;

    pss_req_t eng_req;
    pss_res_t eng_res;
    pss_res_t out_data_reg;
    logic     out_valid_reg;
    logic     eng_idle;
    logic     eng_done;
    logic     res_ready;
    logic     start;

    assign eng_req   = '{func: req.func, priority_req: req.priority_req, mode: req.mode};
    assign req.ready = eng_idle;
    assign start     = req.valid && eng_idle;
    assign res_ready = !out_valid_reg || rsp.ready;

    pss_engine u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (eng_req),
        .res_ready (res_ready),
        .idle      (eng_idle),
        .done      (eng_done),
        .res       (eng_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (eng_done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_done)
        begin
            out_data_reg <= eng_res;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_data_reg.status;
    assign rsp.slot          = out_data_reg.slot;
    assign rsp.slot_priority = out_data_reg.slot_priority;
    assign rsp.slot_mode     = out_data_reg.slot_mode;

endmodule

@@ rtl/core/pss_checker.sv @@
// port-level checks for the priority-sweep process scheduler, with its bind
// depends on pss_pkg; attached to priority_sweep_process_scheduler
`timescale 1ns / 1ps

module pss_checker
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   req_valid,
    input logic                   req_ready,
    input logic                   rsp_valid,
    input logic                   rsp_ready,
    input logic [pss_pkg::STATUS_W-1:0] status,
    input logic [pss_pkg::SLOT_W-1:0]   slot,
    input logic [pss_pkg::PRIO_W-1:0]   slot_priority,
    input logic                   slot_mode
);
    import pss_pkg::*;

    // stalled response stays up
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    // stalled response keeps its payload
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(status) && $stable(slot)
            && $stable(slot_priority) && $stable(slot_mode))
        else $error("response payload changed while stalled");

    // one request in work at a time
    a_req_single: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while engine busy");

    // failed add and pick with nothing runnable carry zero fields
    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == STATUS_FULL || status == STATUS_NONE)
            |-> slot == '0 && slot_priority == '0 && slot_mode == 1'b0)
        else $error("nonzero fields on a failed response");

endmodule

bind priority_sweep_process_scheduler pss_checker u_pss_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .status        (rsp.status),
    .slot          (rsp.slot),
    .slot_priority (rsp.slot_priority),
    .slot_mode     (rsp.slot_mode)
);
